FILE: rtl/core/swcrm_pkg.sv
// Shared constants, types and helpers for the sliding-window count rate meter.
package swcrm_pkg;

    localparam int LONG_WINDOW  = 60;
    localparam int SHORT_WINDOW = 10;
    localparam int EFF_SHORT    = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;

    localparam int COUNT_W     = 16;
    localparam int DIV_W       = 8;
    localparam int SHORT_OUT_W = 20;
    localparam int LONG_OUT_W  = 22;
    localparam int DEC_W       = 2;

    localparam int POS_W       = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
    localparam int TICK_W      = $clog2(LONG_WINDOW + 1);
    localparam int SHORT_SUM_W = $clog2(EFF_SHORT * 65535 + 1);
    localparam int LONG_SUM_W  = $clog2(LONG_WINDOW * 65535 + 1);
    localparam int SCALED_W    = (LONG_SUM_W > 17) ? LONG_SUM_W : 17;
    localparam int DCNT_W      = $clog2(SCALED_W);

    // Queue depth between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] SMALL_LIMIT = 32'd6554;
    localparam logic [31:0] MAX20       = 32'h000F_FFFF;
    localparam logic [31:0] MAX22       = 32'h003F_FFFF;

    localparam logic [DIV_W-1:0] DIVISOR_RESET = 8'd15;
    localparam logic [DEC_W-1:0] DEC_ONE       = 2'd1;
    localparam logic [DEC_W-1:0] DEC_TWO       = 2'd2;

    // APB register indexes
    localparam logic REG_DOSE_DIVISOR = 1'b0;
    localparam int   PADDR_W          = 3;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] delta;
    } delta_beat_t;

    function automatic logic [SHORT_OUT_W-1:0] sat20(input logic [31:0] v);
        logic [31:0] r;
        r = (v > MAX20) ? MAX20 : v;
        return r[SHORT_OUT_W-1:0];
    endfunction

    function automatic logic [LONG_OUT_W-1:0] sat22(input logic [31:0] v);
        logic [31:0] r;
        r = (v > MAX22) ? MAX22 : v;
        return r[LONG_OUT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/sliding_window_count_rate_meter.sv
// Top level of the sliding-window count rate meter.
//
// Input channel (in_valid/in_ready, counter_reading): one beat per one-second
// tick carrying the free-running 16-bit pulse counter. The front takes the
// beat, forms the wrapped delta and queues it (two entries deep).
// Output channel (out_valid/out_ready): one beat per input beat with the
// 10 s and 60 s sums, their valid flags, the dose value and its decimal count.
// Each beat goes from dequeue to output through the ring reads and sum update
// over the single-read-port count RAM, a scaling step, the bit-serial divider
// (one quotient bit per cycle) and one output load. The back part takes no new
// beat from the queue until the current one has been loaded for output.
// The result sits in an output register; while the receiver stalls, the back
// part finishes its next item and holds it, and the front keeps taking beats
// until the queue is full, after which in_ready drops.
// Reset clears the sums, tick count, previous reading and ring valid bits at
// once (no clearing pass); dose_divisor returns to 15.
// APB: dose_divisor at byte address 0, written on psel & penable & pwrite.
module sliding_window_count_rate_meter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swcrm_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swcrm_pkg::COUNT_W-1:0]     counter_reading,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swcrm_pkg::SHORT_OUT_W-1:0] short_sum,
    output logic [swcrm_pkg::LONG_OUT_W-1:0]  long_sum,
    output logic [swcrm_pkg::LONG_OUT_W-1:0]  dose_value,
    output logic [swcrm_pkg::DEC_W-1:0]       dose_decimals,
    output logic                              short_valid,
    output logic                              long_valid
);
    import swcrm_pkg::*;

    logic [DIV_W-1:0] dose_divisor_reg;
    logic             reg_sel;
    delta_beat_t      push;
    delta_beat_t      head;
    logic             pop;
    logic             queue_full;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign prdata  = (reg_sel == REG_DOSE_DIVISOR) ? {24'd0, dose_divisor_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dose_divisor_reg <= DIVISOR_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_sel == REG_DOSE_DIVISOR))
        begin
            dose_divisor_reg <= pwdata[DIV_W-1:0];
        end
    end

    swcrm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .counter_reading (counter_reading),
        .queue_full      (queue_full),
        .push            (push)
    );

    swcrm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    swcrm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .dose_divisor  (dose_divisor_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .short_sum     (short_sum),
        .long_sum      (long_sum),
        .dose_value    (dose_value),
        .dose_decimals (dose_decimals),
        .short_valid   (short_valid),
        .long_valid    (long_valid)
    );

endmodule

FILE: rtl/core/swcrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swcrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/swcrm_queue.sv
// Short FIFO of per-second deltas between the front and back parts.
module swcrm_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swcrm_pkg::delta_beat_t push,
    input  logic                   pop,
    output swcrm_pkg::delta_beat_t head,
    output logic                   full
);
    import swcrm_pkg::*;

    logic [COUNT_W-1:0] store [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.delta = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push.delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/swcrm_front.sv
// Input side: accepts counter readings and forms the wrapped per-second delta.
module swcrm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swcrm_pkg::COUNT_W-1:0] counter_reading,
    input  logic                          queue_full,
    output swcrm_pkg::delta_beat_t        push
);
    import swcrm_pkg::*;

    logic [COUNT_W-1:0] prev_reading_reg;
    logic               accept;

    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    // modulo-65536 difference falls out of the 16-bit subtract
    assign push.valid = accept;
    assign push.delta = counter_reading - prev_reading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reading_reg <= '0;
        end
        else if (accept)
        begin
            prev_reading_reg <= counter_reading;
        end
    end

endmodule

FILE: rtl/core/swcrm_back.sv
// Back part: ring update, running sums, dose division and output register.
module swcrm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  swcrm_pkg::delta_beat_t            head,
    output logic                              pop,
    input  logic [swcrm_pkg::DIV_W-1:0]       dose_divisor,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swcrm_pkg::SHORT_OUT_W-1:0] short_sum,
    output logic [swcrm_pkg::LONG_OUT_W-1:0]  long_sum,
    output logic [swcrm_pkg::LONG_OUT_W-1:0]  dose_value,
    output logic [swcrm_pkg::DEC_W-1:0]       dose_decimals,
    output logic                              short_valid,
    output logic                              long_valid
);
    import swcrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_SHORT,
        S_RD_LONG,
        S_UPDATE,
        S_SCALE,
        S_DIV,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [COUNT_W-1:0]     delta_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [TICK_W-1:0]      ticks_reg;
    logic [SHORT_SUM_W-1:0] short_total_reg;
    logic [LONG_SUM_W-1:0]  long_total_reg;
    logic [LONG_WINDOW-1:0] entry_valid_reg;
    logic [DIV_W-1:0]       rem_reg;
    logic [SCALED_W-1:0]    dq_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic [DEC_W-1:0]       dec_reg;

    logic                   out_valid_reg;
    logic [SHORT_OUT_W-1:0] short_sum_reg;
    logic [LONG_OUT_W-1:0]  long_sum_reg;
    logic [LONG_OUT_W-1:0]  dose_value_reg;
    logic [DEC_W-1:0]       dose_decimals_reg;
    logic                   short_valid_reg;
    logic                   long_valid_reg;

    logic [POS_W:0]         spos_wide;
    logic [POS_W-1:0]       spos;
    logic [POS_W-1:0]       pos_inc;
    logic [POS_W-1:0]       ram_raddr;
    logic                   ram_re;
    logic                   ram_we;
    logic [COUNT_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]     old_short;
    logic [COUNT_W-1:0]     old_long;
    logic [SCALED_W-1:0]    scaled;
    logic                   is_small;
    logic [DIV_W:0]         rem_shift;
    logic                   rem_ge;
    logic [DIV_W-1:0]       rem_step;
    logic                   out_free;

    // start of the short window, modulo the ring length
    always_comb
    begin
        if ({1'b0, pos_reg} >= (POS_W + 1)'(EFF_SHORT))
        begin
            spos_wide = {1'b0, pos_reg} - (POS_W + 1)'(EFF_SHORT);
        end
        else
        begin
            spos_wide = {1'b0, pos_reg} + (POS_W + 1)'(LONG_WINDOW - EFF_SHORT);
        end
    end
    assign spos = spos_wide[POS_W-1:0];

    assign pos_inc = (pos_reg == POS_W'(LONG_WINDOW - 1)) ? '0 : pos_reg + 1'b1;

    assign ram_re    = (state_reg == S_RD_SHORT) || (state_reg == S_RD_LONG);
    assign ram_raddr = (state_reg == S_RD_SHORT) ? spos : pos_reg;
    assign ram_we    = (state_reg == S_UPDATE);

    swcrm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (delta_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written since reset read as zero
    assign old_short = entry_valid_reg[spos] ? ram_rdata : '0;
    assign old_long  = entry_valid_reg[pos_reg] ? ram_rdata : '0;

    assign is_small = (32'(long_total_reg) < SMALL_LIMIT);
    assign scaled   = is_small ? ((SCALED_W'(long_total_reg) << 3) + (SCALED_W'(long_total_reg) << 1))
                               : SCALED_W'(long_total_reg);

    // one restoring-division step per cycle
    assign rem_shift = {rem_reg, dq_reg[SCALED_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dose_divisor});
    assign rem_step  = rem_ge ? DIV_W'(rem_shift - {1'b0, dose_divisor}) : rem_shift[DIV_W-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pos_reg           <= '0;
            ticks_reg         <= '0;
            short_total_reg   <= '0;
            long_total_reg    <= '0;
            entry_valid_reg   <= '0;
            out_valid_reg     <= 1'b0;
            delta_reg         <= '0;
            rem_reg           <= '0;
            dq_reg            <= '0;
            dcnt_reg          <= '0;
            dec_reg           <= DEC_ONE;
            short_sum_reg     <= '0;
            long_sum_reg      <= '0;
            dose_value_reg    <= '0;
            dose_decimals_reg <= DEC_ONE;
            short_valid_reg   <= 1'b0;
            long_valid_reg    <= 1'b0;
        end
        else
        begin
            // in S_DONE the load below decides out_valid on its own
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        delta_reg <= head.delta;
                        state_reg <= S_RD_SHORT;
                    end
                end
                S_RD_SHORT:
                begin
                    state_reg <= S_RD_LONG;
                end
                S_RD_LONG:
                begin
                    short_total_reg <= short_total_reg - SHORT_SUM_W'(old_short)
                                       + SHORT_SUM_W'(delta_reg);
                    state_reg       <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    long_total_reg           <= long_total_reg - LONG_SUM_W'(old_long)
                                                + LONG_SUM_W'(delta_reg);
                    entry_valid_reg[pos_reg] <= 1'b1;
                    pos_reg                  <= pos_inc;
                    if (ticks_reg != TICK_W'(LONG_WINDOW))
                    begin
                        ticks_reg <= ticks_reg + 1'b1;
                    end
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    rem_reg   <= '0;
                    dq_reg    <= scaled;
                    dcnt_reg  <= '0;
                    dec_reg   <= is_small ? DEC_TWO : DEC_ONE;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_step;
                    dq_reg   <= {dq_reg[SCALED_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(SCALED_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        short_sum_reg     <= sat20(32'(short_total_reg));
                        long_sum_reg      <= sat22(32'(long_total_reg));
                        dose_value_reg    <= (dose_divisor == '0) ? MAX22[LONG_OUT_W-1:0]
                                                                  : sat22(32'(dq_reg));
                        dose_decimals_reg <= dec_reg;
                        short_valid_reg   <= (int'(ticks_reg) >= SHORT_WINDOW);
                        long_valid_reg    <= (int'(ticks_reg) >= LONG_WINDOW);
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign short_sum     = short_sum_reg;
    assign long_sum      = long_sum_reg;
    assign dose_value    = dose_value_reg;
    assign dose_decimals = dose_decimals_reg;
    assign short_valid   = short_valid_reg;
    assign long_valid    = long_valid_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < LONG_WINDOW)
        else $error("ring position out of range");

    a_ticks_sat: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ticks_reg) <= LONG_WINDOW)
        else $error("tick count past saturation");

    a_dec_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (dose_decimals_reg == DEC_ONE || dose_decimals_reg == DEC_TWO))
        else $error("bad decimal count");

    a_dec_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dose_decimals_reg == DEC_ONE) |-> (32'(long_sum_reg) >= SMALL_LIMIT))
        else $error("one decimal reported for a small long sum");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_RD_SHORT))
        else $error("delta popped without starting an update");

endmodule

FILE: tb/sliding_window_count_rate_meter_test.sv
// Self-checking testbench for the sliding-window count rate meter.
`timescale 1ns / 100ps

module sliding_window_count_rate_meter_test;
    import swcrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 64;

    typedef struct packed {
        logic [SHORT_OUT_W-1:0] short_sum;
        logic [LONG_OUT_W-1:0]  long_sum;
        logic [LONG_OUT_W-1:0]  dose_value;
        logic [DEC_W-1:0]       dose_decimals;
        logic                   short_valid;
        logic                   long_valid;
    } rate_beat_t;

    typedef enum int {
        DELTA_TINY,
        DELTA_FEW,
        DELTA_EDGE,
        DELTA_MAX,
        DELTA_NONE,
        READ_ANY,
        DELTA_ANY
    } reading_style_t;

    class rate_meter_board_t;
        rate_beat_t         pending_rates[$];
        int                 errors;
        logic [COUNT_W-1:0] sec_counts[LONG_WINDOW];
        int unsigned        short_acc;
        int unsigned        long_acc;
        int unsigned        slot;
        int unsigned        ticks;
        logic [COUNT_W-1:0] last_reading;
        logic [DIV_W-1:0]   divisor;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (sec_counts[i]) sec_counts[i] = '0;
            short_acc    = 0;
            long_acc     = 0;
            slot         = 0;
            ticks        = 0;
            last_reading = '0;
            divisor      = DIVISOR_RESET;
            pending_rates.delete();
        endfunction

        function void set_divisor(logic [DIV_W-1:0] value);
            divisor = value;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Advance the window by one tick and queue the beat it produces.
        function void note_reading(logic [COUNT_W-1:0] reading);
            logic [COUNT_W-1:0] delta;
            int unsigned        tail_slot;
            int unsigned        scaled;
            int unsigned        quotient;
            rate_beat_t         beat;
            delta        = reading - last_reading;
            last_reading = reading;
            tail_slot    = (slot + LONG_WINDOW - EFF_SHORT) % LONG_WINDOW;
            short_acc    = short_acc - 32'(sec_counts[tail_slot]) + 32'(delta);
            long_acc     = long_acc - 32'(sec_counts[slot]) + 32'(delta);
            sec_counts[slot] = delta;
            slot = (slot + 1 >= LONG_WINDOW) ? 0 : slot + 1;
            if (ticks < LONG_WINDOW)
                ticks++;

            if (long_acc < SMALL_LIMIT)
            begin
                scaled             = long_acc * 10;
                beat.dose_decimals = DEC_TWO;
            end
            else
            begin
                scaled             = long_acc;
                beat.dose_decimals = DEC_ONE;
            end
            if (divisor == 0)
                quotient = MAX22;
            else
                quotient = scaled / divisor;
            if (quotient > MAX22)
                quotient = MAX22;

            beat.short_sum   = (short_acc > MAX20) ? MAX20[SHORT_OUT_W-1:0]
                                                   : short_acc[SHORT_OUT_W-1:0];
            beat.long_sum    = (long_acc > MAX22) ? MAX22[LONG_OUT_W-1:0]
                                                  : long_acc[LONG_OUT_W-1:0];
            beat.dose_value  = quotient[LONG_OUT_W-1:0];
            beat.short_valid = (ticks >= SHORT_WINDOW);
            beat.long_valid  = (ticks >= LONG_WINDOW);
            pending_rates.push_back(beat);
        endfunction

        task check_beat(rate_beat_t got);
            rate_beat_t want;
            if (pending_rates.size() == 0)
            begin
                report("output beat with nothing expected");
                return;
            end
            want = pending_rates.pop_front();
            if (got.short_sum !== want.short_sum)
                report($sformatf("short_sum got %0d want %0d", got.short_sum, want.short_sum));
            if (got.long_sum !== want.long_sum)
                report($sformatf("long_sum got %0d want %0d", got.long_sum, want.long_sum));
            if (got.dose_value !== want.dose_value)
                report($sformatf("dose_value got %0d want %0d",
                                 got.dose_value, want.dose_value));
            if (got.dose_decimals !== want.dose_decimals)
                report($sformatf("dose_decimals got %0d want %0d",
                                 got.dose_decimals, want.dose_decimals));
            if (got.short_valid !== want.short_valid)
                report($sformatf("short_valid got %b want %b",
                                 got.short_valid, want.short_valid));
            if (got.long_valid !== want.long_valid)
                report($sformatf("long_valid got %b want %b",
                                 got.long_valid, want.long_valid));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [COUNT_W-1:0]     counter_reading = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SHORT_OUT_W-1:0] short_sum;
    logic [LONG_OUT_W-1:0]  long_sum;
    logic [LONG_OUT_W-1:0]  dose_value;
    logic [DEC_W-1:0]       dose_decimals;
    logic                   short_valid;
    logic                   long_valid;

    rate_meter_board_t  board;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 hold_requests = 0;
    int                 quiet_cycles = 0;
    logic [COUNT_W-1:0] last_sent = '0;

    logic [COUNT_W-1:0] directed_readings [20] = '{
        16'd0, 16'd6553, 16'd6554, 16'd6554, 16'hFFFF, 16'h0000, 16'h0000,
        16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h8000, 16'h7FFF,
        16'h0001, 16'h0002, 16'hFFFF, 16'hFFFF, 16'h1234, 16'hEDCB
    };

    sliding_window_count_rate_meter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .counter_reading (counter_reading),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .short_sum       (short_sum),
        .long_sum        (long_sum),
        .dose_value      (dose_value),
        .dose_decimals   (dose_decimals),
        .short_valid     (short_valid),
        .long_valid      (long_valid)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus a long counted hold-off on request.
    initial
    begin
        int seen_requests;
        int hold_left;
        seen_requests = 0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != seen_requests)
            begin
                seen_requests = hold_requests;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_beat('{short_sum, long_sum, dose_value, dose_decimals,
                               short_valid, long_valid});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("sliding_window_count_rate_meter_test: done, errors");
            $finish;
        end
    end

    task apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                    input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task check_divisor(logic [DIV_W-1:0] want);
        logic [31:0] rdata;
        apb_access(1'b0, PADDR_W'(REG_DOSE_DIVISOR) << 2, '0, rdata);
        if (rdata[DIV_W-1:0] !== want)
            board.report($sformatf("dose_divisor read %0d want %0d", rdata[DIV_W-1:0], want));
    endtask

    task write_divisor(logic [DIV_W-1:0] value);
        logic [31:0] rdata;
        apb_access(1'b1, PADDR_W'(REG_DOSE_DIVISOR) << 2, 32'(value), rdata);
        board.set_divisor(value);
        check_divisor(value);
    endtask

    task wait_drained(int extra);
        while (board.pending_rates.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task send_reading(logic [COUNT_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        counter_reading <= value;
        do @(posedge clk); while (!in_ready);
        board.note_reading(value);
        last_sent = value;
    endtask

    task stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Bursts of one delta style, so the window sums swing across the whole range.
    task send_random(int count);
        reading_style_t     style;
        int                 burst_left;
        logic [COUNT_W-1:0] next;
        burst_left = 0;
        style      = DELTA_ANY;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                style      = reading_style_t'($urandom_range(0, 6));
                burst_left = $urandom_range(20, 120);
            end
            burst_left--;
            case (style)
                DELTA_TINY: next = last_sent + COUNT_W'($urandom_range(0, 20));
                DELTA_FEW:  next = last_sent + COUNT_W'($urandom_range(0, 300));
                DELTA_EDGE: next = last_sent + COUNT_W'($urandom_range(105, 114));
                DELTA_MAX:  next = last_sent - 1'b1;
                DELTA_NONE: next = last_sent;
                READ_ANY:   next = COUNT_W'($urandom);
                default:    next = last_sent + COUNT_W'($urandom_range(0, 65535));
            endcase
            send_reading(next);
        end
        stop_sending();
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_divisor(DIVISOR_RESET);

        // directed: counter extremes, wrap, full overrun, decimal boundary
        tx_idle_pct = 21;
        rx_idle_pct = 70;
        foreach (directed_readings[i])
            send_reading(directed_readings[i]);
        stop_sending();
        wait_drained(40);

        write_divisor(8'd1);
        send_random(430);
        wait_drained(40);

        tx_idle_pct = 70;
        rx_idle_pct = 21;
        write_divisor(8'd255);
        send_random(430);
        wait_drained(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_divisor(8'd0);
        send_random(80);
        wait_drained(40);

        write_divisor(DIV_W'($urandom_range(1, 255)));
        hold_requests = hold_requests + 1;
        send_random(360);
        wait_drained(SETTLE_CYCLES);

        if (board.pending_rates.size() != 0)
            board.report($sformatf("%0d expected beats never arrived",
                                   board.pending_rates.size()));
        if (board.errors == 0)
            $display("sliding_window_count_rate_meter_test: done, clean");
        else
            $display("sliding_window_count_rate_meter_test: done, errors");
        $finish;
    end

endmodule

FILE: sliding_window_count_rate_meter.f
rtl/core/swcrm_pkg.sv
rtl/core/swcrm_ram.sv
rtl/core/swcrm_queue.sv
rtl/core/swcrm_front.sv
rtl/core/swcrm_back.sv
rtl/core/sliding_window_count_rate_meter.sv
tb/sliding_window_count_rate_meter_test.sv
